### rtl/core/cordic_pkg.sv
// Shared types, constants and the arctangent table for the CORDIC unit.
`timescale 1ns / 1ps
`default_nettype none

package cordic_pkg;

    localparam int ITERATIONS = 28;
    localparam int TABLE_LEN  = 30;
    localparam int IDX_W      = $clog2(TABLE_LEN);
    localparam int WORD_W     = 32;
    localparam int COORD_W    = 30;
    localparam int GAIN_W     = 30;
    localparam int FRAC_Q30   = 30;

    localparam logic [WORD_W-1:0] PI_Q28      = 32'd843314857;
    localparam logic [WORD_W-1:0] PI_HALF_Q28 = 32'd421657428;
    localparam logic [WORD_W-1:0] ONE_Q30     = 32'd1073741824;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 30'd652032874;

    localparam logic REQ_ROTATE = 1'b0;
    localparam logic REQ_VECTOR = 1'b1;

    typedef struct packed {
        logic              vec_mode;
        logic              negate;
        logic              refl;
        logic              flag;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
    } cell_t;

    // Arctangent of 2^-i in Q28, rounded to nearest.
    function automatic logic [WORD_W-1:0] atan_q28(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 32'd210828714;
                5'd1:    val = 32'd124459457;
                5'd2:    val = 32'd65760959;
                5'd3:    val = 32'd33381290;
                5'd4:    val = 32'd16755422;
                5'd5:    val = 32'd8385879;
                5'd6:    val = 32'd4193963;
                5'd7:    val = 32'd2097109;
                5'd8:    val = 32'd1048571;
                5'd9:    val = 32'd524287;
                5'd10:   val = 32'd262144;
                5'd11:   val = 32'd131072;
                5'd12:   val = 32'd65536;
                5'd13:   val = 32'd32768;
                5'd14:   val = 32'd16384;
                5'd15:   val = 32'd8192;
                5'd16:   val = 32'd4096;
                5'd17:   val = 32'd2048;
                5'd18:   val = 32'd1024;
                5'd19:   val = 32'd512;
                5'd20:   val = 32'd256;
                5'd21:   val = 32'd128;
                5'd22:   val = 32'd64;
                5'd23:   val = 32'd32;
                5'd24:   val = 32'd16;
                5'd25:   val = 32'd8;
                5'd26:   val = 32'd4;
                5'd27:   val = 32'd2;
                5'd28:   val = 32'd1;
                default: val = 32'd0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/cordic_cell.sv
// One CORDIC iteration cell: a shift-add micro-rotation followed by a register.
`timescale 1ns / 1ps
`default_nettype none

module cordic_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [cordic_pkg::IDX_W-1:0] idx,
    input  wire logic                         in_valid,
    input  wire cordic_pkg::cell_t            in_data,
    output logic                              out_valid,
    output cordic_pkg::cell_t                 out_data
);

    logic signed [cordic_pkg::WORD_W-1:0] x_s;
    logic signed [cordic_pkg::WORD_W-1:0] y_s;
    logic        [cordic_pkg::WORD_W-1:0] dx;
    logic        [cordic_pkg::WORD_W-1:0] dy;
    logic        [cordic_pkg::WORD_W-1:0] step;
    logic                                 up;
    logic                                 valid_reg;
    cordic_pkg::cell_t                    data_reg;
    cordic_pkg::cell_t                    data_next;

    assign x_s  = in_data.x;
    assign y_s  = in_data.y;
    assign dx   = y_s >>> idx;
    assign dy   = x_s >>> idx;
    assign step = cordic_pkg::atan_q28(idx);

    // Vectoring drives y toward zero; rotation drives the residual angle toward zero.
    assign up = in_data.vec_mode ? ~in_data.y[cordic_pkg::WORD_W-1]
                                 : in_data.z[cordic_pkg::WORD_W-1];

    always_comb
    begin
        data_next = in_data;
        if (up)
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + step;
        end
        else
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### rtl/core/cordic_scale.sv
// Gain scaling, result folding and the output register of the CORDIC unit.
`timescale 1ns / 1ps
`default_nettype none

module cordic_scale (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire cordic_pkg::cell_t                 in_data,
    input  wire logic [cordic_pkg::GAIN_W-1:0]     gain,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [cordic_pkg::WORD_W-1:0]          sin_out,
    output logic [cordic_pkg::WORD_W-1:0]          cos_out,
    output logic [cordic_pkg::WORD_W-1:0]          angle_out,
    output logic                                   range_flag
);

    localparam int PROD_W = cordic_pkg::WORD_W + cordic_pkg::GAIN_W + 1;
    localparam int LSB    = cordic_pkg::FRAC_Q30;
    localparam int MSB    = cordic_pkg::FRAC_Q30 + cordic_pkg::WORD_W - 1;

    logic signed [cordic_pkg::WORD_W-1:0]   x_s;
    logic signed [cordic_pkg::WORD_W-1:0]   y_s;
    logic signed [cordic_pkg::GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]               prod_x_next;
    logic signed [PROD_W-1:0]               prod_y_next;
    logic signed [PROD_W-1:0]               prod_x_reg;
    logic signed [PROD_W-1:0]               prod_y_reg;
    logic                                   mul_valid_reg;
    cordic_pkg::cell_t                      side_reg;
    logic        [cordic_pkg::WORD_W-1:0]   cos_scaled;
    logic        [cordic_pkg::WORD_W-1:0]   sin_scaled;
    logic        [cordic_pkg::WORD_W-1:0]   sin_next;
    logic        [cordic_pkg::WORD_W-1:0]   cos_next;
    logic        [cordic_pkg::WORD_W-1:0]   angle_next;
    logic                                   z_le_zero;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic        [cordic_pkg::WORD_W-1:0]   sin_reg;
    logic        [cordic_pkg::WORD_W-1:0]   cos_reg;
    logic        [cordic_pkg::WORD_W-1:0]   angle_reg;
    logic                                   flag_reg;

    assign x_s         = in_data.x;
    assign y_s         = in_data.y;
    assign gain_s      = {1'b0, gain};
    assign prod_x_next = x_s * gain_s;
    assign prod_y_next = y_s * gain_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            side_reg   <= in_data;
        end
    end

    assign cos_scaled = prod_x_reg[MSB:LSB];
    assign sin_scaled = prod_y_reg[MSB:LSB];
    assign z_le_zero  = side_reg.z[cordic_pkg::WORD_W-1] || (side_reg.z == '0);

    always_comb
    begin
        sin_next   = side_reg.negate ? ('0 - sin_scaled) : sin_scaled;
        cos_next   = side_reg.negate ? ('0 - cos_scaled) : cos_scaled;
        angle_next = side_reg.z;
        if (side_reg.vec_mode)
        begin
            sin_next = '0;
            cos_next = '0;
            if (side_reg.refl)
            begin
                angle_next = z_le_zero ? (side_reg.z + cordic_pkg::PI_Q28)
                                       : (side_reg.z - cordic_pkg::PI_Q28);
            end
        end
    end

    assign out_valid_next = mul_valid_reg | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_valid_reg)
        begin
            sin_reg   <= sin_next;
            cos_reg   <= cos_next;
            angle_reg <= angle_next;
            flag_reg  <= side_reg.flag & ~side_reg.vec_mode;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sin_out    = sin_reg;
    assign cos_out    = cos_reg;
    assign angle_out  = angle_reg;
    assign range_flag = flag_reg;

endmodule

`default_nettype wire

### rtl/core/cordic_sincos_atan2_unit.sv
// Top level of the CORDIC unit: input folding, the chain of iteration cells and scaling.
`timescale 1ns / 1ps
`default_nettype none

// The unit handles one item at a time. An accepted item is folded into the first
// register, passes one iteration cell per cycle along a chain of 28 cells, then goes
// through the gain multiply register and the output register. The next item is
// accepted in the cycle after the result is taken.
module cordic_sincos_atan2_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [29:0] cfg_wdata,     // gain_q30
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // angle_in, x_in, y_in, zero padding
    input  wire logic [0:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,  // sin_out, cos_out, angle_out
    output logic [0:0]       m_axis_tuser   // range_flag
);

    localparam int N = cordic_pkg::ITERATIONS;
    localparam int W = cordic_pkg::WORD_W;
    localparam int C = cordic_pkg::COORD_W;

    logic [cordic_pkg::GAIN_W-1:0]   gain_reg;
    logic                            busy_reg;
    logic                            busy_next;
    logic                            in_accept;
    logic                            out_accept;
    logic                            stage0_valid_reg;
    cordic_pkg::cell_t               stage0_reg;
    cordic_pkg::cell_t               stage0_next;
    logic signed [W-1:0]             angle_s;
    logic signed [W-1:0]             x_ext;
    logic signed [W-1:0]             y_ext;
    logic                            chain_valid [0:N];
    cordic_pkg::cell_t               chain_data  [0:N];
    logic [W-1:0]                    sin_out;
    logic [W-1:0]                    cos_out;
    logic [W-1:0]                    angle_out;
    logic                            range_flag;

    assign in_accept  = s_axis_tvalid & s_axis_tready;
    assign out_accept = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= cordic_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            gain_reg <= cfg_wdata;
        end
    end

    assign busy_next = in_accept ? 1'b1 : (out_accept ? 1'b0 : busy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign s_axis_tready = ~busy_reg;

    assign angle_s = s_axis_tdata[W-1:0];
    assign x_ext   = W'($signed(s_axis_tdata[W+C-1:W]));
    assign y_ext   = W'($signed(s_axis_tdata[W+2*C-1:W+C]));

    // Rotation folds the angle into the right half plane; vectoring reflects a negative x.
    always_comb
    begin
        stage0_next          = '0;
        stage0_next.vec_mode = s_axis_tuser[0];
        if (s_axis_tuser[0] == cordic_pkg::REQ_ROTATE)
        begin
            stage0_next.x    = cordic_pkg::ONE_Q30;
            stage0_next.y    = '0;
            stage0_next.z    = angle_s;
            stage0_next.flag = (angle_s > $signed(cordic_pkg::PI_Q28))
                            || (angle_s < $signed('0 - cordic_pkg::PI_Q28));
            if (angle_s > $signed(cordic_pkg::PI_HALF_Q28))
            begin
                stage0_next.z      = angle_s - cordic_pkg::PI_Q28;
                stage0_next.negate = 1'b1;
            end
            else if (angle_s < $signed('0 - cordic_pkg::PI_HALF_Q28))
            begin
                stage0_next.z      = angle_s + cordic_pkg::PI_Q28;
                stage0_next.negate = 1'b1;
            end
        end
        else
        begin
            stage0_next.z = '0;
            if (x_ext[W-1])
            begin
                stage0_next.x    = '0 - x_ext;
                stage0_next.y    = '0 - y_ext;
                stage0_next.refl = 1'b1;
            end
            else
            begin
                stage0_next.x = x_ext;
                stage0_next.y = y_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage0_valid_reg <= 1'b0;
        end
        else
        begin
            stage0_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage0_reg <= stage0_next;
        end
    end

    assign chain_valid[0] = stage0_valid_reg;
    assign chain_data[0]  = stage0_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (cordic_pkg::IDX_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    cordic_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chain_valid[N]),
        .in_data    (chain_data[N]),
        .gain       (gain_reg),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .sin_out    (sin_out),
        .cos_out    (cos_out),
        .angle_out  (angle_out),
        .range_flag (range_flag)
    );

    assign m_axis_tdata    = {angle_out, cos_out, sin_out};
    assign m_axis_tuser[0] = range_flag;

endmodule

`default_nettype wire

### rtl/core/cordic_checker.sv
// Port-level checks for the CORDIC unit and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module cordic_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [95:0] m_axis_tdata,
    input  wire logic [0:0]  m_axis_tuser
);

    // A stalled result must hold its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("Stalled result changed before it was taken.");

    // Only one item is in flight, so acceptance closes the input side.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("Input accepted a second item while one was in flight.");

    // A pending result and an open input never coexist.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("Input ready while a result is still pending.");

    // Taking the result frees the unit for the next item.
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> (s_axis_tready && !m_axis_tvalid))
        else $error("Unit did not return to idle after its result was taken.");

endmodule

bind cordic_sincos_atan2_unit cordic_checker u_cordic_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### tb/cordic_sincos_atan2_unit_tb.sv
// Self-checking testbench for the CORDIC sine/cosine and atan2 unit.
`timescale 1ns / 1ps

module cordic_sincos_atan2_unit_tb;

    localparam int     CYCLE_LIMIT = 600000;
    localparam int     HOLD_CYCLES = 400;
    localparam int     N_DIRECTED  = 25;
    localparam int     N_STEPS     = (cordic_pkg::ITERATIONS > cordic_pkg::TABLE_LEN)
                                   ? cordic_pkg::TABLE_LEN : cordic_pkg::ITERATIONS;
    localparam logic        ROTATE        = cordic_pkg::REQ_ROTATE;
    localparam logic        VECTOR        = cordic_pkg::REQ_VECTOR;
    localparam logic [31:0] PI_ANGLE      = cordic_pkg::PI_Q28;
    localparam logic [31:0] HALF_PI_ANGLE = cordic_pkg::PI_HALF_Q28;
    localparam logic [31:0] NEG_PI      = 32'd0 - PI_ANGLE;
    localparam logic [31:0] NEG_HALF_PI = 32'd0 - HALF_PI_ANGLE;
    localparam logic [29:0] C_MAX       = 30'h1FFF_FFFF;
    localparam logic [29:0] C_MIN       = 30'h2000_0000;
    localparam logic [29:0] GAIN_MAX    = 30'h3FFF_FFFF;
    localparam logic [1:0]  PIN_NONE    = 2'b00;
    localparam logic [1:0]  PIN_FLAG    = 2'b01;
    localparam logic [1:0]  PIN_ALL     = 2'b11;

    localparam logic [31:0] ARCTAN_Q28 [0:29] = '{
        32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290, 32'd16755422,
        32'd8385879, 32'd4193963, 32'd2097109, 32'd1048571, 32'd524287,
        32'd262144, 32'd131072, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
        32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
        32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    typedef struct packed {
        logic        req;
        logic [31:0] angle;
        logic [29:0] x;
        logic [29:0] y;
        logic [1:0]  pin;
        logic [31:0] sin_v;
        logic [31:0] cos_v;
        logic        flag_v;
    } trig_req_t;

    typedef struct packed {
        logic [31:0] sin_v;
        logic [31:0] cos_v;
        logic [31:0] angle;
        logic        flag;
    } trig_res_t;

    // Rotation rows have the range flag typed in; vectoring rows also sin and cos.
    localparam trig_req_t DIRECTED [0:N_DIRECTED-1] = '{
        '{ROTATE, 32'd0,                 30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b0},
        '{ROTATE, 32'h7FFF_FFFF,         30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b1},
        '{ROTATE, 32'h8000_0000,         30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b1},
        '{ROTATE, PI_ANGLE,              30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b0},
        '{ROTATE, PI_ANGLE + 32'd1,      30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b1},
        '{ROTATE, NEG_PI,                30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b0},
        '{ROTATE, NEG_PI - 32'd1,        30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b1},
        '{ROTATE, HALF_PI_ANGLE,         30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b0},
        '{ROTATE, HALF_PI_ANGLE + 32'd1, 30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b0},
        '{ROTATE, NEG_HALF_PI,           30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b0},
        '{ROTATE, NEG_HALF_PI - 32'd1,   30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b0},
        '{ROTATE, 32'hFFFF_FFFF,         30'd0,   30'd0,   PIN_FLAG, 32'd0, 32'd0, 1'b0},
        '{ROTATE, 32'd12345,             C_MIN,   C_MAX,   PIN_FLAG, 32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'd0,                 30'd1,   30'd0,   PIN_ALL,  32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'd0,                 C_MAX,   C_MAX,   PIN_ALL,  32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'd0,                 C_MIN,   C_MIN,   PIN_ALL,  32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'd0,                 C_MIN,   30'd0,   PIN_ALL,  32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'd0,                 -30'sd1, 30'd0,   PIN_ALL,  32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'd0,                 30'd0,   30'd0,   PIN_ALL,  32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'd0,                 30'd0,   C_MAX,   PIN_ALL,  32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'd0,                 30'd0,   C_MIN,   PIN_ALL,  32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'd0,                 C_MAX,   C_MIN,   PIN_ALL,  32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'd0,                 -30'sd5, 30'd3,   PIN_ALL,  32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'd0,                 -30'sd5, -30'sd3, PIN_ALL,  32'd0, 32'd0, 1'b0},
        '{VECTOR, 32'hFFFF_FFFF,         C_MAX,   -30'sd1, PIN_ALL,  32'd0, 32'd0, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [29:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;     // angle_in, x_in, y_in, zero padding
    logic [0:0]  s_axis_tuser = '0;     // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;          // sin_out, cos_out, angle_out
    logic [0:0]  m_axis_tuser;          // range_flag

    logic [29:0] gain_now = cordic_pkg::GAIN_RESET;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_phase = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          errors = 0;
    int          cycles = 0;
    trig_res_t   pending_trig [$];

    cordic_sincos_atan2_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] apply_gain(input logic [31:0] v);
        logic signed [63:0] prod;
        begin
            prod = $signed({{32{v[31]}}, v}) * $signed({34'd0, gain_now});
            prod = prod >>> 30;
            return prod[31:0];
        end
    endfunction

    function automatic trig_res_t predict_trig(input trig_req_t rq);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] dx;
        logic [31:0] dy;
        logic        flip;
        trig_res_t   r;
        begin
            r = '0;
            flip = 1'b0;
            if (rq.req == ROTATE)
            begin
                x = cordic_pkg::ONE_Q30;
                y = 32'd0;
                z = rq.angle;
                r.flag = ($signed(z) > $signed(PI_ANGLE)) || ($signed(z) < $signed(NEG_PI));
                if ($signed(z) > $signed(HALF_PI_ANGLE))
                begin
                    z = z - PI_ANGLE;
                    flip = 1'b1;
                end
                else if ($signed(z) < $signed(NEG_HALF_PI))
                begin
                    z = z + PI_ANGLE;
                    flip = 1'b1;
                end
                for (int i = 0; i < N_STEPS; i++)
                begin
                    dx = $signed(y) >>> i;
                    dy = $signed(x) >>> i;
                    if (!z[31])
                    begin
                        x = x - dx;
                        y = y + dy;
                        z = z - ARCTAN_Q28[i];
                    end
                    else
                    begin
                        x = x + dx;
                        y = y - dy;
                        z = z + ARCTAN_Q28[i];
                    end
                end
                r.cos_v = apply_gain(x);
                r.sin_v = apply_gain(y);
                if (flip)
                begin
                    r.cos_v = 32'd0 - r.cos_v;
                    r.sin_v = 32'd0 - r.sin_v;
                end
            end
            else
            begin
                x = {{2{rq.x[29]}}, rq.x};
                y = {{2{rq.y[29]}}, rq.y};
                z = 32'd0;
                if (x[31])
                begin
                    x = 32'd0 - x;
                    y = 32'd0 - y;
                    flip = 1'b1;
                end
                for (int i = 0; i < N_STEPS; i++)
                begin
                    dx = $signed(y) >>> i;
                    dy = $signed(x) >>> i;
                    if (!y[31])
                    begin
                        x = x + dx;
                        y = y - dy;
                        z = z + ARCTAN_Q28[i];
                    end
                    else
                    begin
                        x = x - dx;
                        y = y + dy;
                        z = z - ARCTAN_Q28[i];
                    end
                end
                if (flip)
                begin
                    if (z[31] || z == 32'd0)
                        z = z + PI_ANGLE;
                    else
                        z = z - PI_ANGLE;
                end
            end
            r.angle = z;
            if (rq.pin[0])
                r.flag = rq.flag_v;
            if (rq.pin[1])
            begin
                r.sin_v = rq.sin_v;
                r.cos_v = rq.cos_v;
            end
            return r;
        end
    endfunction

    function automatic logic [29:0] pick_coord();
        begin
            case ($urandom_range(5))
                0: return C_MAX;
                1: return C_MIN;
                2: return 30'd0;
                3: return 30'($signed($urandom_range(0, 8)) - 4);
                4: return 30'($signed($urandom_range(0, 2000)) - 1000);
                default: return 30'($urandom);
            endcase
        end
    endfunction

    function automatic trig_req_t random_item();
        trig_req_t rq;
        logic [31:0] base;
        begin
            rq = '0;
            rq.pin = PIN_NONE;
            rq.angle = $urandom;
            rq.x = 30'($urandom);
            rq.y = 30'($urandom);
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    rq.req = ROTATE;
                    rq.angle = $urandom_range(0, 2 * PI_ANGLE) - PI_ANGLE;
                end
                4:
                    rq.req = ROTATE;
                5:
                begin
                    rq.req = ROTATE;
                    case ($urandom_range(4))
                        0: base = PI_ANGLE;
                        1: base = NEG_PI;
                        2: base = HALF_PI_ANGLE;
                        3: base = NEG_HALF_PI;
                        default: base = 32'd0;
                    endcase
                    rq.angle = base + $urandom_range(0, 8) - 32'd4;
                end
                6, 7, 8:
                    rq.req = VECTOR;
                default:
                begin
                    rq.req = VECTOR;
                    rq.x = pick_coord();
                    rq.y = pick_coord();
                end
            endcase
            return rq;
        end
    endfunction

    task automatic offer(input trig_req_t rq);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                s_axis_tvalid = 1'b0;
                @(negedge clk);
            end
            s_axis_tdata = {4'd0, rq.y, rq.x, rq.angle};
            s_axis_tuser = rq.req;
            s_axis_tvalid = 1'b1;
            do
                @(posedge clk);
            while (!s_axis_tready);
            pending_trig.push_back(predict_trig(rq));
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_trig.size() != 0)
                @(posedge clk);
            repeat (8) @(negedge clk);
        end
    endtask

    task automatic write_gain(input logic [29:0] g);
        begin
            wait_drained();
            cfg_wdata = g;
            cfg_we = 1'b1;
            gain_now = g;
            @(negedge clk);
            cfg_we = 1'b0;
        end
    endtask

    task automatic run_phase(input logic [29:0] g, input int idle, input int stall,
                             input logic hold, input int count);
        begin
            write_gain(g);
            idle_pct = idle;
            stall_pct = stall;
            hold_phase = hold;
            for (int k = 0; k < count; k++)
                offer(random_item());
            s_axis_tvalid = 1'b0;
            hold_phase = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        begin
            if (exp_v !== got_v)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
                errors++;
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_phase && !hold_seen)
            hold_left = HOLD_CYCLES;
        hold_seen = hold_phase;
        if (hold_left > 0)
        begin
            m_axis_tready = 1'b0;
            hold_left--;
        end
        else
            m_axis_tready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        trig_res_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_trig.size() == 0)
            begin
                $display("%0t: result with no item pending, actual %h %h", $time,
                         m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                e = pending_trig.pop_front();
                check_field("sin_out", e.sin_v, m_axis_tdata[31:0]);
                check_field("cos_out", e.cos_v, m_axis_tdata[63:32]);
                check_field("angle_out", e.angle, m_axis_tdata[95:64]);
                check_field("range_flag", {31'd0, e.flag}, {31'd0, m_axis_tuser[0]});
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results pending", $time, pending_trig.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        for (int k = 0; k < N_DIRECTED; k++)
            offer(DIRECTED[k]);
        s_axis_tvalid = 1'b0;

        run_phase(GAIN_MAX, 0, 0, 1'b0, 250);
        run_phase(30'd0, 82, 0, 1'b0, 200);
        run_phase(30'($urandom), 0, 82, 1'b0, 200);
        run_phase(cordic_pkg::GAIN_RESET, 36, 36, 1'b0, 300);
        run_phase(30'($urandom), 0, 0, 1'b1, 300);

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_trig.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
